@@ hdl/core_slot_allocator_core_assert.svh @@
// ---------------------------------------------------------------------------
// core slot allocator assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef CORE_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define CORE_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("core slot allocator check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("core slot allocator check failed");

// delayed implication
`define CSA_ASSERT_TWO(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("core slot allocator check failed");

`endif

@@ hdl/csa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_pkg
// fixed field widths, operation codes and state type of the core slot
// allocator
// ---------------------------------------------------------------------------
package csa_pkg;

  // fixed field widths
  localparam int FUNC_W = 3;
  localparam int CORE_W = 4;
  localparam int TID_W  = 22;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PIN_PREF  = 3'd0,
    FN_PIN_FIRST = 3'd1,
    FN_SET_FREE  = 3'd2,
    FN_RELEASE   = 3'd3,
    FN_QUERY     = 3'd4,
    FN_FIND_FREE = 3'd5
  } csa_func_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } csa_state_t;

endpackage

@@ hdl/csa_occ_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_occ_table
// occupant thread id per core, one write port and one registered read port
// ---------------------------------------------------------------------------
module csa_occ_table #(
  parameter int DEPTH  = 16,
  parameter int AW     = 4,
  parameter int DW     = 22
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/csa_pick.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_pick
// priority encoder: lowest free core at or above a start index
// ---------------------------------------------------------------------------
module csa_pick #(
  parameter int NUM_CORES = 16,
  parameter int CW        = 4,
  parameter int IW        = 5
) (
  input  logic [NUM_CORES-1:0] free_vec,
  input  logic [IW-1:0]        start,
  output logic                 found,
  output logic [CW-1:0]        idx
);

  logic [NUM_CORES-1:0] elig;
  logic [NUM_CORES-1:0] lowbit;

  // free cores not below the start index
  always_comb begin
    for (int i = 0; i < NUM_CORES; i++) begin
      elig[i] = free_vec[i] & (IW'(unsigned'(i)) >= start);
    end
  end

  // isolate lowest eligible bit and encode it
  assign lowbit = elig & (~elig + NUM_CORES'(1));
  assign found  = |elig;

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      idx = idx | (lowbit[i] ? CW'(unsigned'(i)) : '0);
    end
  end

endmodule

@@ hdl/core_slot_allocator_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// core_slot_allocator_core
// thread-to-core slot allocator: pin, set, release, query and free search
// ---------------------------------------------------------------------------
// In the accept cycle of a request the occupant table is read at
// target_core, and in the following cycle the request is evaluated
// against the read data and the occupancy mask, the table is written on a
// placement and the mask updated. The result strobe (out_valid) is a one-cycle
// strobe in the cycle after the evaluate cycle; busy is high only in the evaluate
// cycle, so a new request can be taken while a result is on the ports, but
// not while one is being evaluated. Results cannot be stalled by the receiver.
// All cores are free after reset.
module core_slot_allocator_core #(
  parameter int NUM_CORES = 16,
  parameter int TID_BITS  = 22
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [csa_pkg::FUNC_W-1:0] in_func,
  input  logic [csa_pkg::CORE_W-1:0] in_target_core,
  input  logic [csa_pkg::TID_W-1:0]  in_thread_id,
  // result channel
  output logic                       out_valid,
  output logic                       out_success,
  output logic [csa_pkg::CORE_W-1:0] out_granted_core,
  output logic                       out_slot_free,
  output logic [csa_pkg::TID_W-1:0]  out_occupant
);

  // core index width, extended width for range compare, stored tid width
  localparam int CW = $clog2(NUM_CORES);
  localparam int IW = ((CW > csa_pkg::CORE_W) ? CW : csa_pkg::CORE_W) + 1;
  localparam int TW = (TID_BITS < csa_pkg::TID_W) ? TID_BITS : csa_pkg::TID_W;

  csa_pkg::csa_state_t state_r, state_nxt;

  logic                       accept;
  logic [IW-1:0]              in_core_ext;

  // request registers
  logic [csa_pkg::FUNC_W-1:0] func_r;
  logic [IW-1:0]              core_r;
  logic [TW-1:0]              tid_r;

  logic [NUM_CORES-1:0]       mask_r, mask_nxt;

  // result registers
  logic                       out_valid_r, out_valid_nxt;
  logic                       success_r, success_nxt;
  logic [csa_pkg::CORE_W-1:0] granted_r, granted_nxt;
  logic                       sfree_r, sfree_nxt;
  logic [csa_pkg::TID_W-1:0]  occ_r, occ_nxt;

  // table port and search signals
  logic                       wr_en;
  logic [CW-1:0]              wr_addr;
  logic [TW-1:0]              rd_data;
  logic [CW-1:0]              core_idx;
  logic                       in_range;
  logic                       core_busy;
  logic [IW-1:0]              pick_start;
  logic                       pick_found;
  logic [CW-1:0]              pick_idx;
  logic [IW-1:0]              pick_ext;
  logic [IW-1:0]              grant_ext;

  assign accept      = start & ~busy;
  assign in_core_ext = IW'(in_target_core);

  // occupant table
  csa_occ_table #(
    .DEPTH (NUM_CORES),
    .AW    (CW),
    .DW    (TW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tid_r),
    .rd_en   (accept),
    .rd_addr (in_core_ext[CW-1:0]),
    .rd_data (rd_data)
  );

  // free core search
  assign pick_start = (func_r == csa_pkg::FN_FIND_FREE) ? core_r : '0;

  csa_pick #(
    .NUM_CORES (NUM_CORES),
    .CW        (CW),
    .IW        (IW)
  ) u_pick (
    .free_vec (~mask_r),
    .start    (pick_start),
    .found    (pick_found),
    .idx      (pick_idx)
  );

  assign core_idx  = core_r[CW-1:0];
  assign in_range  = core_r < IW'(NUM_CORES);
  assign core_busy = mask_r[core_idx];
  assign pick_ext  = IW'(pick_idx);

  // request capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      core_r <= in_core_ext;
      tid_r  <= in_thread_id[TW-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csa_pkg::ST_IDLE;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    success_r <= success_nxt;
    granted_r <= granted_nxt;
    sfree_r   <= sfree_nxt;
    occ_r     <= occ_nxt;
  end

  // sequencer: next state, evaluation and table update
  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    success_nxt   = 1'b0;
    grant_ext     = '0;
    sfree_nxt     = 1'b0;
    occ_nxt       = '0;
    wr_en         = 1'b0;
    wr_addr       = core_idx;
    busy          = 1'b0;

    case (state_r)
      csa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = csa_pkg::ST_EXEC;
        end
      end
      csa_pkg::ST_EXEC: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = csa_pkg::ST_IDLE;
        case (func_r)
          csa_pkg::FN_PIN_PREF, csa_pkg::FN_SET_FREE: begin
            if (in_range && !core_busy) begin
              wr_en     = 1'b1;
              wr_addr   = core_idx;
              success_nxt = 1'b1;
              grant_ext = core_r;
            end else if (func_r == csa_pkg::FN_PIN_PREF && pick_found) begin
              wr_en     = 1'b1;
              wr_addr   = pick_idx;
              success_nxt = 1'b1;
              grant_ext = pick_ext;
            end
          end
          csa_pkg::FN_PIN_FIRST: begin
            if (pick_found) begin
              wr_en     = 1'b1;
              wr_addr   = pick_idx;
              success_nxt = 1'b1;
              grant_ext = pick_ext;
            end
          end
          csa_pkg::FN_RELEASE: begin
            if (in_range && core_busy && rd_data == tid_r) begin
              mask_nxt[core_idx] = 1'b0;
              success_nxt = 1'b1;
              grant_ext   = core_r;
            end
          end
          csa_pkg::FN_QUERY: begin
            if (in_range) begin
              success_nxt = 1'b1;
              grant_ext   = core_r;
              if (core_busy) begin
                occ_nxt = csa_pkg::TID_W'(rd_data);
              end else begin
                sfree_nxt = 1'b1;
              end
            end
          end
          csa_pkg::FN_FIND_FREE: begin
            if (pick_found) begin
              success_nxt = 1'b1;
              grant_ext   = pick_ext;
            end
          end
          default: begin
          end
        endcase
        if (wr_en) begin
          mask_nxt[wr_addr] = 1'b1;
        end
      end
      default: begin
        state_nxt = csa_pkg::ST_IDLE;
      end
    endcase
    granted_nxt = grant_ext[csa_pkg::CORE_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_success      = success_r;
  assign out_granted_core = granted_r;
  assign out_slot_free    = sfree_r;
  assign out_occupant     = occ_r;

endmodule

@@ hdl/csa_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csa_checker
// port-level timing and result consistency checks, bound to the top level
// ---------------------------------------------------------------------------
`include "core_slot_allocator_core_assert.svh"

module csa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_success,
  input logic [csa_pkg::CORE_W-1:0] out_granted_core,
  input logic                       out_slot_free,
  input logic [csa_pkg::TID_W-1:0]  out_occupant
);

  logic fields_clear;

  // no core, no free flag and no occupant on the result ports
  assign fields_clear = (out_granted_core == '0) && !out_slot_free && (out_occupant == '0);

  // an accepted transaction raises busy, blocking the next one
  `CSA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

  // every accepted transaction returns its result on out_valid
  `CSA_ASSERT_TWO(a_result_latency, start && !busy, out_valid)

  // a failed transaction carries no core, no free flag and no occupant
  `CSA_ASSERT_NOW(a_fail_zero, out_valid && !out_success, fields_clear)

  // a free slot reported by a query has no occupant
  `CSA_ASSERT_NOW(a_free_no_occ, out_valid && out_slot_free, out_success && out_occupant == '0)

endmodule

bind core_slot_allocator_core csa_checker u_csa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_success      (out_success),
  .out_granted_core (out_granted_core),
  .out_slot_free    (out_slot_free),
  .out_occupant     (out_occupant)
);

@@ tb/tb_core_slot_allocator_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_core_slot_allocator_core
// self-checking bench for the core slot allocator: a directed table covers
// the empty and full table, unused selectors, refused sets and releases and
// the field extremes; random traffic then alternates between filling and
// draining the table under several sender idling patterns, with every
// result compared against a behavioural model of the slot table
// ---------------------------------------------------------------------------
module tb_core_slot_allocator_core;

  localparam int NUM_CORES = 16;
  localparam int TID_MAX   = (1 << csa_pkg::TID_W) - 1;
  localparam int RAND_PER_PHASE = 305;
  // selectors the block decodes as no-ops
  localparam logic [csa_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [csa_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                       success;
    logic [csa_pkg::CORE_W-1:0] granted;
    logic                       slot_free;
    logic [csa_pkg::TID_W-1:0]  occupant;
  } alloc_res_t;

  typedef struct packed {
    logic [csa_pkg::FUNC_W-1:0] func;
    logic [csa_pkg::CORE_W-1:0] core;
    logic [csa_pkg::TID_W-1:0]  tid;
    logic                       fixed;
    alloc_res_t                 res;
  } req_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [csa_pkg::FUNC_W-1:0] in_func = '0;
  logic [csa_pkg::CORE_W-1:0] in_target_core = '0;
  logic [csa_pkg::TID_W-1:0]  in_thread_id = '0;
  logic                       out_valid;
  logic                       out_success;
  logic [csa_pkg::CORE_W-1:0] out_granted_core;
  logic                       out_slot_free;
  logic [csa_pkg::TID_W-1:0]  out_occupant;

  // hand-written expectation travelling with the current transaction
  logic       use_fixed = 1'b0;
  alloc_res_t fixed_res = '0;

  // model of the slot table
  logic [NUM_CORES-1:0]      taken_mask = '0;
  logic [csa_pkg::TID_W-1:0] core_owner [NUM_CORES];

  alloc_res_t outcomes_due [$];
  req_row_t   plan [$];
  logic [csa_pkg::TID_W-1:0] tid_pool [4];

  alloc_res_t model_res;
  alloc_res_t want;
  int mismatches  = 0;
  int accepted    = 0;
  int checked     = 0;
  int grants      = 0;
  int table_full  = 0;

  core_slot_allocator_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_target_core   (in_target_core),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_success      (out_success),
    .out_granted_core (out_granted_core),
    .out_slot_free    (out_slot_free),
    .out_occupant     (out_occupant)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // lowest free core at or above first, NUM_CORES when none
  function automatic int lowest_free_from(input int first);
    int i;
    for (i = first; i < NUM_CORES; i++)
      if (!taken_mask[i]) return i;
    return NUM_CORES;
  endfunction

  // outcome of one request, updating the table model as the block would
  function automatic alloc_res_t slot_outcome(input logic [csa_pkg::FUNC_W-1:0] fn,
                                              input logic [csa_pkg::CORE_W-1:0] core,
                                              input logic [csa_pkg::TID_W-1:0] tid);
    alloc_res_t r;
    int pick;
    r = '0;
    case (fn)
      csa_pkg::FN_PIN_PREF, csa_pkg::FN_PIN_FIRST: begin
        if (fn == csa_pkg::FN_PIN_PREF && !taken_mask[core]) pick = int'(core);
        else pick = lowest_free_from(0);
        if (pick < NUM_CORES) begin
          taken_mask[pick] = 1'b1;
          core_owner[pick] = tid;
          r.success = 1'b1;
          r.granted = pick[csa_pkg::CORE_W-1:0];
        end else begin
          table_full++;
        end
      end
      csa_pkg::FN_SET_FREE: begin
        if (!taken_mask[core]) begin
          taken_mask[core] = 1'b1;
          core_owner[core] = tid;
          r.success = 1'b1;
          r.granted = core;
        end
      end
      csa_pkg::FN_RELEASE: begin
        if (taken_mask[core] && core_owner[core] == tid) begin
          taken_mask[core] = 1'b0;
          r.success = 1'b1;
          r.granted = core;
        end
      end
      csa_pkg::FN_QUERY: begin
        r.success = 1'b1;
        r.granted = core;
        if (taken_mask[core]) r.occupant = core_owner[core];
        else r.slot_free = 1'b1;
      end
      csa_pkg::FN_FIND_FREE: begin
        pick = lowest_free_from(int'(core));
        if (pick < NUM_CORES) begin
          r.success = 1'b1;
          r.granted = pick[csa_pkg::CORE_W-1:0];
        end
      end
      default: ;
    endcase
    if (r.success) grants++;
    return r;
  endfunction

  // record the expectation of each accepted transaction and check results
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0) begin
      model_res = slot_outcome(in_func, in_target_core, in_thread_id);
      outcomes_due.push_back(use_fixed ? fixed_res : model_res);
      accepted++;
    end
    if (rst_n && out_valid === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        checked++;
        if (out_success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, out_success);
          mismatches++;
        end
        if (out_granted_core !== want.granted) begin
          $error("granted_core: expected %0d, got %0d", want.granted, out_granted_core);
          mismatches++;
        end
        if (out_slot_free !== want.slot_free) begin
          $error("slot_free: expected %0d, got %0d", want.slot_free, out_slot_free);
          mismatches++;
        end
        if (out_occupant !== want.occupant) begin
          $error("occupant: expected 0x%06h, got 0x%06h", want.occupant, out_occupant);
          mismatches++;
        end
      end
    end
  end

  // add one row to the directed table
  task automatic plan_row(input logic [csa_pkg::FUNC_W-1:0] fn, input int core,
                          input int tid, input bit fixed, input bit s, input int g,
                          input bit fr, input int occ);
    req_row_t row;
    row.func = fn;
    row.core = core[csa_pkg::CORE_W-1:0];
    row.tid  = tid[csa_pkg::TID_W-1:0];
    row.fixed = fixed;
    row.res.success   = s;
    row.res.granted   = g[csa_pkg::CORE_W-1:0];
    row.res.slot_free = fr;
    row.res.occupant  = occ[csa_pkg::TID_W-1:0];
    plan.push_back(row);
  endtask

  // present one transaction and hold it until the block takes it
  task automatic issue(input req_row_t row);
    in_func        <= row.func;
    in_target_core <= row.core;
    in_thread_id   <= row.tid;
    use_fixed      <= row.fixed;
    fixed_res      <= row.res;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // random run of idle cycles on the request side
  task automatic hold_off(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has come back or the limit runs out
  task automatic drain(input int limit);
    int w;
    start <= 1'b0;
    @(posedge clk);
    for (w = 0; w < limit && outcomes_due.size() != 0; w++) @(posedge clk);
  endtask

  initial begin
    req_row_t row;
    int idle_pct [4];
    int ph, k, r, n;
    idle_pct = '{0, 70, 0, 26};
    tid_pool[0] = '0;
    tid_pool[1] = csa_pkg::TID_W'(TID_MAX);
    tid_pool[2] = csa_pkg::TID_W'($urandom);
    tid_pool[3] = csa_pkg::TID_W'($urandom);

    // directed table: fixed expectations where obvious, model elsewhere
    plan_row(csa_pkg::FN_QUERY,     0,  0,        1, 1, 0,  1, 0);   // empty table
    plan_row(csa_pkg::FN_FIND_FREE, 15, 0,        1, 1, 15, 0, 0);
    plan_row(FN_SPARE_LO,           15, TID_MAX,  1, 0, 0,  0, 0);
    plan_row(FN_SPARE_HI,           0,  TID_MAX,  1, 0, 0,  0, 0);
    plan_row(csa_pkg::FN_PIN_PREF,  15, TID_MAX,  1, 1, 15, 0, 0);
    plan_row(csa_pkg::FN_QUERY,     15, 0,        1, 1, 15, 0, TID_MAX);
    plan_row(csa_pkg::FN_PIN_PREF,  15, 0,        1, 1, 0,  0, 0);   // preferred busy
    plan_row(csa_pkg::FN_SET_FREE,  15, 1,        1, 0, 0,  0, 0);   // set on busy core
    plan_row(csa_pkg::FN_RELEASE,   15, 0,        1, 0, 0,  0, 0);   // wrong thread
    plan_row(csa_pkg::FN_RELEASE,   15, TID_MAX,  1, 1, 15, 0, 0);
    plan_row(csa_pkg::FN_RELEASE,   15, TID_MAX,  1, 0, 0,  0, 0);   // already free
    plan_row(csa_pkg::FN_PIN_FIRST, 9,  'h2AAAAA, 1, 1, 1,  0, 0);
    plan_row(csa_pkg::FN_SET_FREE,  7,  'h155555, 1, 1, 7,  0, 0);
    for (n = 0; n < 13; n++) plan_row(csa_pkg::FN_PIN_FIRST, n, $urandom, 0, 0, 0, 0, 0);
    // table now full
    plan_row(csa_pkg::FN_PIN_PREF,  3,  5,        1, 0, 0,  0, 0);
    plan_row(csa_pkg::FN_PIN_FIRST, 0,  5,        1, 0, 0,  0, 0);
    plan_row(csa_pkg::FN_FIND_FREE, 0,  0,        1, 0, 0,  0, 0);
    plan_row(csa_pkg::FN_QUERY,     7,  0,        1, 1, 7,  0, 'h155555);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i]);
    drain(100);

    // random traffic, alternating drain-heavy and fill-heavy stretches
    row.fixed = 1'b0;
    row.res   = '0;
    for (ph = 0; ph < 4; ph++) begin
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (((k / 64) % 2) == 0) begin
          if (r < 5)       row.func = csa_pkg::FN_PIN_PREF;
          else if (r < 9)  row.func = csa_pkg::FN_PIN_FIRST;
          else if (r < 14) row.func = csa_pkg::FN_SET_FREE;
          else if (r < 70) row.func = csa_pkg::FN_RELEASE;
          else if (r < 84) row.func = csa_pkg::FN_QUERY;
          else if (r < 97) row.func = csa_pkg::FN_FIND_FREE;
          else row.func = (r < 99) ? FN_SPARE_LO : FN_SPARE_HI;
        end else begin
          if (r < 30)      row.func = csa_pkg::FN_PIN_PREF;
          else if (r < 50) row.func = csa_pkg::FN_PIN_FIRST;
          else if (r < 62) row.func = csa_pkg::FN_SET_FREE;
          else if (r < 74) row.func = csa_pkg::FN_RELEASE;
          else if (r < 86) row.func = csa_pkg::FN_QUERY;
          else if (r < 97) row.func = csa_pkg::FN_FIND_FREE;
          else row.func = (r < 99) ? FN_SPARE_LO : FN_SPARE_HI;
        end
        row.core = csa_pkg::CORE_W'($urandom_range(0, NUM_CORES - 1));
        // a small pool of threads lets releases find their owner
        if ($urandom_range(0, 99) < 80) row.tid = tid_pool[$urandom_range(0, 3)];
        else row.tid = csa_pkg::TID_W'($urandom);
        issue(row);
        hold_off(idle_pct[ph]);
      end
      drain(1000);
    end

    repeat (4) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      $error("%0d results never arrived", outcomes_due.size());
      mismatches++;
    end

    $display("%0d requests accepted, %0d results checked, %0d successful", accepted,
             checked, grants);
    $display("placement refused on a full table %0d times; %0d mismatches", table_full,
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
